// ===== sv/pfde_pkg.sv =====
// Shared types and constants for the page framebuffer draw engine.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package pfde_pkg;

    // Depth of the command queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_PIXEL = 2'd1,
        OP_RECT  = 2'd2,
        OP_READ  = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t    opcode;
        logic [7:0] x_pos;
        logic [7:0] y_pos;
        logic [7:0] width_px;
        logic [7:0] height_px;
        logic       pixel_on;
        logic [7:0] fill_byte;
    } cmd_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       dropped;
    } rsp_item_t;

    // Classified command as the back executes it. Pixel and rectangle share
    // one inclusive box; skip marks a command that touches no memory.
    typedef struct packed {
        opcode_t    op;
        logic [7:0] x_lo;
        logic [7:0] x_hi;
        logic [7:0] y_lo;
        logic [7:0] y_hi;
        logic       pixel_on;
        logic [7:0] fill_byte;
        logic       buf_sel;
        logic       skip;
        logic       dropped;
    } work_t;

    typedef enum logic [2:0] {
        BK_INIT,
        BK_IDLE,
        BK_CLEAR,
        BK_RD,
        BK_WR,
        BK_DONE
    } back_state_t;

endpackage

`default_nettype wire

// ===== sv/pfde_front.sv =====
// Front of the draw engine: holds the buffer select register, accepts
// requests, clips them and pushes classified work into the queue.
// Depends on pfde_pkg.
`default_nettype none

module pfde_front
    import pfde_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64,
    parameter int BUFFER_COUNT  = 2
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_wr_en,
    input  wire logic      cfg_wr_data,
    input  wire logic      cmd_valid,
    output logic           cmd_ready,
    input  wire cmd_item_t cmd,
    input  wire logic      init_done,
    input  wire logic      q_full,
    output logic           q_push,
    output work_t          q_data
);

    localparam logic [8:0] SW9 = 9'(SCREEN_WIDTH);
    localparam logic [8:0] SH9 = 9'(SCREEN_HEIGHT);

    logic       draw_buffer_reg;
    logic       off;
    logic [8:0] x_sum;
    logic [8:0] y_sum;
    logic [8:0] w_clip;
    logic [8:0] h_clip;
    logic [8:0] x_end;
    logic [8:0] y_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draw_buffer_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            draw_buffer_reg <= cfg_wr_data;
        end
    end

    // Requests wait while the store is being swept clean after reset or the queue is full.
    assign cmd_ready = init_done && !q_full;
    assign q_push    = cmd_valid && cmd_ready;

    always_comb
    begin
        off    = ({1'b0, cmd.x_pos} >= SW9) || ({1'b0, cmd.y_pos} >= SH9);
        x_sum  = {1'b0, cmd.x_pos} + {1'b0, cmd.width_px};
        y_sum  = {1'b0, cmd.y_pos} + {1'b0, cmd.height_px};
        w_clip = (x_sum > SW9) ? (SW9 - {1'b0, cmd.x_pos}) : {1'b0, cmd.width_px};
        h_clip = (y_sum > SH9) ? (SH9 - {1'b0, cmd.y_pos}) : {1'b0, cmd.height_px};
        x_end  = {1'b0, cmd.x_pos} + w_clip - 9'd1;
        y_end  = {1'b0, cmd.y_pos} + h_clip - 9'd1;

        q_data.op        = cmd.opcode;
        q_data.x_lo      = cmd.x_pos;
        q_data.y_lo      = cmd.y_pos;
        q_data.x_hi      = cmd.x_pos;
        q_data.y_hi      = cmd.y_pos;
        q_data.pixel_on  = cmd.pixel_on;
        q_data.fill_byte = cmd.fill_byte;
        q_data.buf_sel   = (BUFFER_COUNT > 1) ? draw_buffer_reg : 1'b0;
        q_data.skip      = off;
        q_data.dropped   = off;

        case (cmd.opcode)
            OP_CLEAR:
            begin
                q_data.skip    = 1'b0;
                q_data.dropped = 1'b0;
            end
            OP_RECT:
            begin
                q_data.x_hi = x_end[7:0];
                q_data.y_hi = y_end[7:0];
                // An empty rectangle does nothing but is not a drop.
                q_data.skip = off || (w_clip == 9'd0) || (h_clip == 9'd0);
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/pfde_queue.sv =====
// Short command queue between the front and the back of the draw engine.
// Depends on pfde_pkg for the entry type and the depth.
`default_nettype none

module pfde_queue
    import pfde_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire work_t din,
    output logic       full,
    input  wire logic  pop,
    output logic       valid,
    output work_t      dout
);

    work_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign dout  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !(pop && valid))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop && valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop && valid)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

// ===== sv/pfde_back.sv =====
// Back of the draw engine: owns the frame store, sweeps it clean after reset,
// executes queued work one byte at a time and holds the response register.
// Depends on pfde_pkg.
`default_nettype none

module pfde_back
    import pfde_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64,
    parameter int BUFFER_COUNT  = 2
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  q_valid,
    input  wire work_t q_data,
    output logic       q_pop,
    output logic       init_done,
    output logic       rsp_valid,
    input  wire logic  rsp_ready,
    output rsp_item_t  rsp
);

    localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
    localparam int BUF_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
    localparam int STORE_BYTES = BUFFER_COUNT * BUF_BYTES;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam logic [7:0] LAST_COL  = 8'(SCREEN_WIDTH - 1);
    localparam logic [4:0] LAST_PAGE = 5'(PAGE_COUNT - 1);

    back_state_t       state_reg;
    back_state_t       state_next;
    work_t             work_reg;
    logic [4:0]        page_reg;
    logic [7:0]        col_reg;
    logic [ADDR_W-1:0] init_addr_reg;
    logic [7:0]        rdata_reg;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    rsp_item_t         rsp_reg;

    logic [7:0]        frame_mem [STORE_BYTES];
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        mem_wdata;
    logic [7:0]        row_mask;
    logic [7:0]        rmw_data;
    logic              rsp_load;
    logic              row_last;
    logic              box_last;

    function automatic logic [ADDR_W-1:0] byte_addr(input logic b, input logic [4:0] p,
                                                    input logic [7:0] c);
        logic [31:0] a;
        a = 32'(int'(p) * SCREEN_WIDTH) + 32'(c) + (b ? 32'(BUF_BYTES) : 32'd0);
        return a[ADDR_W-1:0];
    endfunction

    assign init_done = (state_reg != BK_INIT);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign row_last  = (col_reg == work_reg.x_hi);
    assign box_last  = row_last && (page_reg == work_reg.y_hi[7:3]);

    // Rows of the current page that fall inside the box.
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            row_mask[k] = ({page_reg, 3'(k)} >= work_reg.y_lo)
                       && ({page_reg, 3'(k)} <= work_reg.y_hi);
        end
        rmw_data = work_reg.pixel_on ? (rdata_reg | row_mask) : (rdata_reg & ~row_mask);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_INIT:
            begin
                if (init_addr_reg == ADDR_W'(STORE_BYTES - 1))
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_data.skip)
                    begin
                        state_next = BK_DONE;
                    end
                    else if (q_data.op == OP_CLEAR)
                    begin
                        state_next = BK_CLEAR;
                    end
                    else
                    begin
                        state_next = BK_RD;
                    end
                end
            end
            BK_CLEAR:
            begin
                if (col_reg == LAST_COL && page_reg == LAST_PAGE)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_RD:
            begin
                state_next = (work_reg.op == OP_READ) ? BK_DONE : BK_WR;
            end
            BK_WR:
            begin
                state_next = box_last ? BK_DONE : BK_RD;
            end
            BK_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_wdata = rmw_data;
        mem_addr  = byte_addr(work_reg.buf_sel, page_reg, col_reg);
        rsp_load  = 1'b0;
        case (state_reg)
            BK_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = 8'h00;
                mem_addr  = init_addr_reg;
            end
            BK_IDLE:
            begin
                q_pop = q_valid;
            end
            BK_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = work_reg.fill_byte;
            end
            BK_RD:
            begin
                mem_re = 1'b1;
            end
            BK_WR:
            begin
                mem_we = 1'b1;
            end
            BK_DONE:
            begin
                rsp_load = !rsp_valid_reg || rsp_ready;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_INIT;
            init_addr_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (state_reg == BK_INIT)
            begin
                init_addr_reg <= init_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    work_reg <= q_data;
                    if (q_data.op == OP_CLEAR)
                    begin
                        col_reg  <= 8'd0;
                        page_reg <= 5'd0;
                    end
                    else
                    begin
                        col_reg  <= q_data.x_lo;
                        page_reg <= q_data.y_lo[7:3];
                    end
                end
            end
            BK_CLEAR:
            begin
                if (col_reg == LAST_COL)
                begin
                    col_reg  <= 8'd0;
                    page_reg <= page_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            BK_WR:
            begin
                if (row_last)
                begin
                    col_reg  <= work_reg.x_lo;
                    page_reg <= page_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            BK_DONE:
            begin
                if (rsp_load)
                begin
                    rsp_reg.dropped   <= work_reg.dropped;
                    rsp_reg.read_data <= (work_reg.op == OP_READ && !work_reg.skip)
                                       ? rdata_reg : 8'h00;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Single port frame store with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= frame_mem[mem_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/page_framebuffer_draw_engine.sv =====
// Top level of the page framebuffer draw engine: buffer select register,
// request front, command queue and execution back with the frame store.
// Depends on pfde_pkg, pfde_front, pfde_queue and pfde_back.
//
// Requests arrive on cmd with cmd_valid/cmd_ready; each request yields exactly
// one response on rsp with rsp_valid/rsp_ready, in request order. The user
// must write the buffer select through cfg_wr_en/cfg_wr_data only while the
// engine is idle; the block does not enforce this. A request enters a four
// entry queue in the cycle it is taken, so the front keeps taking requests
// while the back works or a response waits. The back runs one request at a
// time over the single port frame store: dropped, empty and other no-op
// requests go straight to a response, a read reads one byte, a pixel reads
// and writes one byte, a rectangle each byte it touches (clipped width times
// pages spanned), and a clear writes every byte of a buffer (SCREEN_WIDTH *
// ceil(SCREEN_HEIGHT / 8)). After reset the back sweeps zeros into all
// BUFFER_COUNT * SCREEN_WIDTH * ceil(SCREEN_HEIGHT / 8) bytes of the store
// (2048 by default), one byte a cycle; cmd_ready stays low until the sweep
// ends. When the receiver holds rsp_ready low the response stays in its
// register, the back waits, and the queue fills until cmd_ready drops.
`default_nettype none

module page_framebuffer_draw_engine
    import pfde_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64,
    parameter int BUFFER_COUNT  = 2
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_wr_en,
    input  wire logic      cfg_wr_data,
    input  wire logic      cmd_valid,
    output logic           cmd_ready,
    input  wire cmd_item_t cmd,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    output rsp_item_t      rsp
);

    logic  init_done;
    logic  q_full;
    logic  q_push;
    logic  q_pop;
    logic  q_valid;
    work_t q_in;
    work_t q_out;

    pfde_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .BUFFER_COUNT  (BUFFER_COUNT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .init_done   (init_done),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_in)
    );

    pfde_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_in),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .dout  (q_out)
    );

    pfde_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .BUFFER_COUNT  (BUFFER_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_out),
        .q_pop     (q_pop),
        .init_done (init_done),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
